@@ hw/rtl/adaptive_threshold_step_detector_defines.svh @@
// Assertion macros shared by the step detector RTL.
`ifndef ADAPTIVE_THRESHOLD_STEP_DETECTOR_DEFINES_SVH
`define ADAPTIVE_THRESHOLD_STEP_DETECTOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ATSD_ASSERT_IMPL(lbl, ck, rs, cond, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) (cond) |-> (prop)) \
    else $error("atsd assertion failed");

// Next-cycle implication, checked outside reset.
`define ATSD_ASSERT_NEXT(lbl, ck, rs, cond, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) (cond) |=> (prop)) \
    else $error("atsd assertion failed");

`endif

@@ hw/rtl/atsd_pkg.sv @@
`default_nettype none

package atsd_pkg;

  localparam int SAMPLE_BITS   = 13;
  localparam int COUNT_BITS    = 8;
  localparam int THR_BITS      = 12;
  localparam int STEP_OUT_BITS = 8;
  localparam int ADJ_BITS      = 8;
  localparam int DATA_BITS     = 32;
  localparam int ADDR_BITS     = 5;
  localparam int IDX_BITS      = 3;
  // Common width for comparing deltas against thresholds.
  localparam int CMP_BITS = ((SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS) + 1;

  localparam logic [THR_BITS-1:0] X_THR_RESET     = THR_BITS'(35);
  localparam logic [THR_BITS-1:0] YZ_MIN_RESET    = THR_BITS'(175);
  localparam logic [THR_BITS-1:0] YZ_MAX_RESET    = THR_BITS'(195);
  localparam logic [THR_BITS-1:0] YZ_START_RESET  = THR_BITS'(185);
  localparam logic [ADJ_BITS-1:0] ADJ_STEP_RESET  = ADJ_BITS'(2);
  localparam logic [THR_BITS-1:0] MARGIN_RESET    = THR_BITS'(200);

  typedef enum logic [IDX_BITS-1:0] {
    REG_SESSION   = 3'd0,
    REG_X_THR     = 3'd1,
    REG_YZ_MIN    = 3'd2,
    REG_YZ_MAX    = 3'd3,
    REG_YZ_START  = 3'd4,
    REG_ADJ_STEP  = 3'd5,
    REG_MARGIN    = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [THR_BITS-1:0] thr_min;
    logic [THR_BITS-1:0] thr_max;
    logic [ADJ_BITS-1:0] adjust_step;
    logic [THR_BITS-1:0] margin;
  } adapt_cfg_t;

  // Absolute difference of the two sample magnitudes. The most negative
  // sample has magnitude 2^(SAMPLE_BITS-1), which still fits unsigned.
  function automatic logic [SAMPLE_BITS-1:0] axis_delta(
    input logic signed [SAMPLE_BITS-1:0] cur,
    input logic signed [SAMPLE_BITS-1:0] prev
  );
    logic [SAMPLE_BITS-1:0] mc;
    logic [SAMPLE_BITS-1:0] mp;
    mc = cur[SAMPLE_BITS-1] ? (~cur + 1'b1) : cur;
    mp = prev[SAMPLE_BITS-1] ? (~prev + 1'b1) : prev;
    return (mc >= mp) ? (mc - mp) : (mp - mc);
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/atsd_adapt.sv @@
`default_nettype none

// Qualifies one adaptive axis and computes its raised threshold.
module atsd_adapt (
  input  wire logic signed [atsd_pkg::SAMPLE_BITS-1:0] cur,
  input  wire logic signed [atsd_pkg::SAMPLE_BITS-1:0] prev,
  input  wire logic [atsd_pkg::THR_BITS-1:0]           thr,
  input  wire atsd_pkg::adapt_cfg_t                    cfg,
  output logic                                         hit,
  output logic [atsd_pkg::THR_BITS-1:0]                thr_next
);

  logic [atsd_pkg::SAMPLE_BITS-1:0] delta;
  logic [atsd_pkg::CMP_BITS-1:0]    d_ext;
  logic [atsd_pkg::CMP_BITS-1:0]    t_ext;
  logic [atsd_pkg::CMP_BITS-1:0]    excess;
  logic                             raise;
  logic [atsd_pkg::THR_BITS-1:0]    clamped;
  logic [atsd_pkg::THR_BITS:0]      sum;
  logic [atsd_pkg::THR_BITS-1:0]    raised;

  assign delta  = atsd_pkg::axis_delta(cur, prev);
  assign d_ext  = atsd_pkg::CMP_BITS'(delta);
  assign t_ext  = atsd_pkg::CMP_BITS'(thr);
  assign hit    = d_ext >= t_ext;
  assign excess = d_ext - t_ext;
  assign raise  = hit && (excess > atsd_pkg::CMP_BITS'(cfg.margin));

  // With inverted bounds, thr above the maximum gets it, tested first.
  always_comb begin
    if (thr > cfg.thr_max) begin
      clamped = cfg.thr_max;
    end else if (thr < cfg.thr_min) begin
      clamped = cfg.thr_min;
    end else begin
      clamped = thr;
    end
  end

  assign sum = {1'b0, clamped} + (atsd_pkg::THR_BITS + 1)'(cfg.adjust_step);

  always_comb begin
    if (clamped < cfg.thr_max) begin
      raised = (sum > {1'b0, cfg.thr_max}) ? cfg.thr_max : sum[atsd_pkg::THR_BITS-1:0];
    end else begin
      raised = clamped;
    end
  end

  assign thr_next = raise ? raised : thr;

endmodule

`default_nettype wire

@@ hw/rtl/adaptive_threshold_step_detector.sv @@
// Adaptive threshold step detector.
// Input channel: one accelerometer sample (accel_x/y/z) and a clear_count
// flag per transfer, taken when in_valid is high and in_stall is low.
// Output channel: one result per sample (step_detected, step_count and the
// current Y and Z thresholds), taken when out_valid is high and out_stall low.
// A sample lands in an input register; the delta, compare and clamp logic
// then loads the result register from it once that register is free or its
// result is taken. One sample per cycle is sustained while out_stall is low.
// When out_stall holds the result, the input register still takes one more
// sample; in_stall rises only once both registers are full.
// Reset (rst, synchronous) empties both registers, zeroes the previous
// sample and the step count, loads the thresholds with 185 and restores the
// register defaults. The user writes registers over the APB port only while the
// block is idle; the block does not enforce it. yz_threshold_start is not used.
`default_nettype none

module adaptive_threshold_step_detector (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  // Sample channel
  input  wire logic                                    in_valid,
  output logic                                         in_stall,
  input  wire logic signed [atsd_pkg::SAMPLE_BITS-1:0] accel_x,
  input  wire logic signed [atsd_pkg::SAMPLE_BITS-1:0] accel_y,
  input  wire logic signed [atsd_pkg::SAMPLE_BITS-1:0] accel_z,
  input  wire logic                                    clear_count,
  // Result channel
  output logic                                         out_valid,
  input  wire logic                                    out_stall,
  output logic                                         step_detected,
  output logic [atsd_pkg::STEP_OUT_BITS-1:0]           step_count,
  output logic [atsd_pkg::THR_BITS-1:0]                y_threshold_now,
  output logic [atsd_pkg::THR_BITS-1:0]                z_threshold_now,
  // Register port
  input  wire logic                                    psel,
  input  wire logic                                    penable,
  input  wire logic                                    pwrite,
  input  wire logic [atsd_pkg::ADDR_BITS-1:0]          paddr,
  input  wire logic [atsd_pkg::DATA_BITS-1:0]          pwdata,
  output logic [atsd_pkg::DATA_BITS-1:0]               prdata,
  output logic                                         pready
);

  `include "adaptive_threshold_step_detector_defines.svh"

  // Configuration registers
  logic                              session_enabled;
  logic [atsd_pkg::THR_BITS-1:0]     x_threshold;
  logic [atsd_pkg::THR_BITS-1:0]     yz_threshold_min;
  logic [atsd_pkg::THR_BITS-1:0]     yz_threshold_max;
  logic [atsd_pkg::THR_BITS-1:0]     yz_threshold_start;
  logic [atsd_pkg::ADJ_BITS-1:0]     adjust_step;
  logic [atsd_pkg::THR_BITS-1:0]     overshoot_margin;
  logic                              cfg_write;
  logic [atsd_pkg::IDX_BITS-1:0]     reg_idx;

  // Input register
  logic                              in_full;
  logic signed [atsd_pkg::SAMPLE_BITS-1:0] ax;
  logic signed [atsd_pkg::SAMPLE_BITS-1:0] ay;
  logic signed [atsd_pkg::SAMPLE_BITS-1:0] az;
  logic                              clr;

  // Detector state
  logic signed [atsd_pkg::SAMPLE_BITS-1:0] prev_x;
  logic signed [atsd_pkg::SAMPLE_BITS-1:0] prev_y;
  logic signed [atsd_pkg::SAMPLE_BITS-1:0] prev_z;
  logic [atsd_pkg::THR_BITS-1:0]     y_threshold;
  logic [atsd_pkg::THR_BITS-1:0]     z_threshold;
  logic [atsd_pkg::COUNT_BITS-1:0]   steps;

  // Per-sample logic
  logic                              accept;
  logic                              advance;
  atsd_pkg::adapt_cfg_t              adapt_cfg;
  logic [atsd_pkg::SAMPLE_BITS-1:0]  x_delta;
  logic                              x_hit;
  logic                              y_hit;
  logic                              z_hit;
  logic [atsd_pkg::THR_BITS-1:0]     y_thr_new;
  logic [atsd_pkg::THR_BITS-1:0]     z_thr_new;
  logic [atsd_pkg::THR_BITS-1:0]     y_threshold_next;
  logic [atsd_pkg::THR_BITS-1:0]     z_threshold_next;
  logic                              step_hit;
  logic [atsd_pkg::COUNT_BITS-1:0]   steps_base;
  logic [atsd_pkg::COUNT_BITS-1:0]   steps_next;

  // ---------------------------------------------------------------------
  // Register port
  // ---------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_idx   = paddr[atsd_pkg::IDX_BITS+1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      session_enabled    <= 1'b0;
      x_threshold        <= atsd_pkg::X_THR_RESET;
      yz_threshold_min   <= atsd_pkg::YZ_MIN_RESET;
      yz_threshold_max   <= atsd_pkg::YZ_MAX_RESET;
      yz_threshold_start <= atsd_pkg::YZ_START_RESET;
      adjust_step        <= atsd_pkg::ADJ_STEP_RESET;
      overshoot_margin   <= atsd_pkg::MARGIN_RESET;
    end else if (cfg_write) begin
      case (reg_idx)
        atsd_pkg::REG_SESSION:  session_enabled    <= pwdata[0];
        atsd_pkg::REG_X_THR:    x_threshold        <= pwdata[atsd_pkg::THR_BITS-1:0];
        atsd_pkg::REG_YZ_MIN:   yz_threshold_min   <= pwdata[atsd_pkg::THR_BITS-1:0];
        atsd_pkg::REG_YZ_MAX:   yz_threshold_max   <= pwdata[atsd_pkg::THR_BITS-1:0];
        atsd_pkg::REG_YZ_START: yz_threshold_start <= pwdata[atsd_pkg::THR_BITS-1:0];
        atsd_pkg::REG_ADJ_STEP: adjust_step        <= pwdata[atsd_pkg::ADJ_BITS-1:0];
        atsd_pkg::REG_MARGIN:   overshoot_margin   <= pwdata[atsd_pkg::THR_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      atsd_pkg::REG_SESSION:  prdata = atsd_pkg::DATA_BITS'(session_enabled);
      atsd_pkg::REG_X_THR:    prdata = atsd_pkg::DATA_BITS'(x_threshold);
      atsd_pkg::REG_YZ_MIN:   prdata = atsd_pkg::DATA_BITS'(yz_threshold_min);
      atsd_pkg::REG_YZ_MAX:   prdata = atsd_pkg::DATA_BITS'(yz_threshold_max);
      atsd_pkg::REG_YZ_START: prdata = atsd_pkg::DATA_BITS'(yz_threshold_start);
      atsd_pkg::REG_ADJ_STEP: prdata = atsd_pkg::DATA_BITS'(adjust_step);
      atsd_pkg::REG_MARGIN:   prdata = atsd_pkg::DATA_BITS'(overshoot_margin);
      default:                prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------
  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      in_full <= accept || (in_full && !advance);
      if (advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ax  <= accel_x;
      ay  <= accel_y;
      az  <= accel_z;
      clr <= clear_count;
    end
  end

  // ---------------------------------------------------------------------
  // Detection
  // ---------------------------------------------------------------------
  assign adapt_cfg.thr_min     = yz_threshold_min;
  assign adapt_cfg.thr_max     = yz_threshold_max;
  assign adapt_cfg.adjust_step = adjust_step;
  assign adapt_cfg.margin      = overshoot_margin;

  assign x_delta = atsd_pkg::axis_delta(ax, prev_x);
  assign x_hit   = atsd_pkg::CMP_BITS'(x_delta) >= atsd_pkg::CMP_BITS'(x_threshold);

  atsd_adapt u_adapt_y (
    .cur      (ay),
    .prev     (prev_y),
    .thr      (y_threshold),
    .cfg      (adapt_cfg),
    .hit      (y_hit),
    .thr_next (y_thr_new)
  );

  atsd_adapt u_adapt_z (
    .cur      (az),
    .prev     (prev_z),
    .thr      (z_threshold),
    .cfg      (adapt_cfg),
    .hit      (z_hit),
    .thr_next (z_thr_new)
  );

  // Outside a session the thresholds stay and no step counts, but the
  // clear flag still acts on the count.
  assign y_threshold_next = session_enabled ? y_thr_new : y_threshold;
  assign z_threshold_next = session_enabled ? z_thr_new : z_threshold;
  assign step_hit         = session_enabled && x_hit && (y_hit || z_hit);
  assign steps_base       = clr ? '0 : steps;
  assign steps_next       = steps_base + atsd_pkg::COUNT_BITS'(step_hit);

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x      <= '0;
      prev_y      <= '0;
      prev_z      <= '0;
      y_threshold <= atsd_pkg::YZ_START_RESET;
      z_threshold <= atsd_pkg::YZ_START_RESET;
      steps       <= '0;
    end else if (advance) begin
      prev_x      <= ax;
      prev_y      <= ay;
      prev_z      <= az;
      y_threshold <= y_threshold_next;
      z_threshold <= z_threshold_next;
      steps       <= steps_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      step_detected   <= step_hit;
      step_count      <= steps_next[atsd_pkg::STEP_OUT_BITS-1:0];
      y_threshold_now <= y_threshold_next;
      z_threshold_now <= z_threshold_next;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `ATSD_ASSERT_NEXT(a_in_hold, clk, rst, in_full && !advance, in_full)
  `ATSD_ASSERT_NEXT(a_thr_idle, clk, rst, advance && !session_enabled,
                    $stable(y_threshold) && $stable(z_threshold))
  `ATSD_ASSERT_NEXT(a_cnt_hold, clk, rst, !advance, $stable(steps))
  `ATSD_ASSERT_IMPL(a_hit_sess, clk, rst, step_hit, session_enabled)
  `ATSD_ASSERT_NEXT(a_hit_out, clk, rst, advance && step_hit, out_valid && step_detected)

endmodule

`default_nettype wire
